/* rtl/pwtw_pkg.sv */
// Shared types and codes for the piecewise-linear time warp table.
// Used by pwtw_table, pwtw_lerp and piecewise_linear_time_warp_table.
package pwtw_pkg;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_FWD   = 2'd1,
      REQ_INV   = 2'd2,
      REQ_REMAP = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_ORDER = 2'd3
   } status_code_type;

   typedef struct packed {
      logic nneg;
      logic dneg;
   } lerp_sign_type;

   typedef struct packed {
      logic times;
      logic values;
   } tbl_wen_type;

endpackage

/* rtl/pwtw_table.sv */
// Keypoint storage: local-time and warped-time memories, one write port and
// one registered read port each, sharing addresses. Depends on pwtw_pkg.
module pwtw_table #(
   parameter int DEPTH = 16,
   parameter int W     = 48
) (
   input  logic                       clock,
   input  pwtw_pkg::tbl_wen_type      wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [W-1:0]               wr_time,
   input  logic [W-1:0]               wr_value,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [W-1:0]               rd_time,
   output logic [W-1:0]               rd_value
);
   import pwtw_pkg::*;

   logic [W-1:0] times_mem  [DEPTH];
   logic [W-1:0] values_mem [DEPTH];
   logic [W-1:0] rd_time_ff;
   logic [W-1:0] rd_value_ff;

   always_ff @(posedge clock) begin
      if (wr_en.times) begin
         times_mem[wr_addr] <= wr_time;
      end
      if (wr_en.values) begin
         values_mem[wr_addr] <= wr_value;
      end
      rd_time_ff  <= times_mem[rd_addr];
      rd_value_ff <= values_mem[rd_addr];
   end

   assign rd_time  = rd_time_ff;
   assign rd_value = rd_value_ff;

endmodule

/* rtl/pwtw_lerp.sv */
// Serial interpolation unit: a + (b - a) * n / d, rounded to nearest with ties
// away from zero, saturated. Shift-add multiply, restoring divide. Uses pwtw_pkg.
module pwtw_lerp #(
   parameter int W = 48
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [W-1:0]     base_a,
   input  logic signed [W-1:0]     end_b,
   input  logic [W:0]              num_mag,
   input  logic [W:0]              den_mag,
   input  pwtw_pkg::lerp_sign_type signs,
   output logic                    done,
   output logic signed [W-1:0]     result
);
   import pwtw_pkg::*;

   localparam int TW   = W + 1;
   localparam int PW   = 2 * TW;
   localparam int CNTW = $clog2(PW);
   localparam logic signed [W-1:0] TMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] TMIN = {1'b1, {(W-1){1'b0}}};

   typedef enum logic [2:0] {L_IDLE, L_MUL, L_DIV, L_FIX, L_RND} lstate_type;

   lstate_type          st_ff, st_in;
   logic signed [W-1:0] a_ff, a_in;
   logic                neg_ff, neg_in;
   logic [TW-1:0]       dm_ff, dm_in;
   logic [TW-1:0]       bm_ff, bm_in;
   logic [PW-1:0]       acc_ff, acc_in;
   logic [TW-1:0]       rem_ff, rem_in;
   logic [CNTW-1:0]     cnt_ff, cnt_in;
   logic signed [W-1:0] base_ff, base_in;
   logic [TW-1:0]       frac_ff, frac_in;
   logic                sat_ff, sat_in;
   logic signed [W-1:0] satv_ff, satv_in;
   logic                done_ff, done_in;
   logic signed [W-1:0] res_ff, res_in;

   logic signed [W:0]   diff_ba;
   logic [TW:0]         mul_sum;
   logic [TW:0]         div_sh;
   logic                div_ge;
   logic [TW-1:0]       head_pos;
   logic [TW-1:0]       head_neg;
   logic [PW:0]         amt;
   logic [TW:0]         twice_frac;
   logic                round_up;

   assign diff_ba    = $signed({end_b[W-1], end_b}) - $signed({base_a[W-1], base_a});
   assign mul_sum    = {1'b0, acc_ff[PW-1:TW]} + (acc_ff[0] ? {1'b0, bm_ff} : '0);
   assign div_sh     = {rem_ff, acc_ff[PW-1]};
   assign div_ge     = div_sh >= {1'b0, dm_ff};
   assign head_pos   = TW'($signed({TMAX[W-1], TMAX}) - $signed({a_ff[W-1], a_ff}));
   assign head_neg   = TW'($signed({a_ff[W-1], a_ff}) - $signed({TMIN[W-1], TMIN}));
   assign amt        = {1'b0, acc_ff} + (PW+1)'(rem_ff != '0);
   assign twice_frac = {frac_ff, 1'b0};
   assign round_up   = (twice_frac > {1'b0, dm_ff})
                    || (twice_frac == {1'b0, dm_ff} && frac_ff != '0 && !base_ff[W-1]);

   always_comb begin
      st_in   = st_ff;
      a_in    = a_ff;
      neg_in  = neg_ff;
      dm_in   = dm_ff;
      bm_in   = bm_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      base_in = base_ff;
      frac_in = frac_ff;
      sat_in  = sat_ff;
      satv_in = satv_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      case (st_ff)
         L_IDLE: begin
            if (start) begin
               a_in   = base_a;
               dm_in  = den_mag;
               bm_in  = diff_ba[W] ? TW'(-diff_ba) : TW'(diff_ba);
               neg_in = signs.nneg ^ signs.dneg ^ diff_ba[W];
               acc_in = {{TW{1'b0}}, num_mag};
               rem_in = '0;
               cnt_in = '0;
               if (den_mag == '0) begin
                  res_in  = base_a;
                  done_in = 1'b1;
               end else begin
                  st_in = L_MUL;
               end
            end
         end
         L_MUL: begin
            acc_in = {mul_sum, acc_ff[TW-1:1]};
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(TW - 1)) begin
               cnt_in = '0;
               st_in  = L_DIV;
            end
         end
         L_DIV: begin
            rem_in = div_ge ? TW'(div_sh - {1'b0, dm_ff}) : div_sh[TW-1:0];
            acc_in = {acc_ff[PW-2:0], div_ge};
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(PW - 1)) begin
               st_in = L_FIX;
            end
         end
         L_FIX: begin
            sat_in = 1'b0;
            if (!neg_ff) begin
               satv_in = TMAX;
               sat_in  = acc_ff > {{(PW-TW){1'b0}}, head_pos};
               base_in = a_ff + $signed(acc_ff[W-1:0]);
               frac_in = rem_ff;
            end else begin
               satv_in = TMIN;
               sat_in  = amt > {{(PW+1-TW){1'b0}}, head_neg};
               base_in = a_ff - $signed(amt[W-1:0]);
               frac_in = (rem_ff != '0) ? TW'(dm_ff - rem_ff) : '0;
            end
            st_in = L_RND;
         end
         L_RND: begin
            if (sat_ff) begin
               res_in = satv_ff;
            end else if (round_up) begin
               res_in = (base_ff == TMAX) ? TMAX : base_ff + W'(1);
            end else begin
               res_in = base_ff;
            end
            done_in = 1'b1;
            st_in   = L_IDLE;
         end
         default: begin
            st_in = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= L_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      a_ff    <= a_in;
      neg_ff  <= neg_in;
      dm_ff   <= dm_in;
      bm_ff   <= bm_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      base_ff <= base_in;
      frac_ff <= frac_in;
      sat_ff  <= sat_in;
      satv_ff <= satv_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> st_ff == L_IDLE)
      else $error("interpolation started while busy");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (st_ff == L_DIV || st_ff == L_FIX) |-> rem_ff < dm_ff)
      else $error("partial remainder not below divisor");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> st_ff == L_IDLE)
      else $error("done raised while busy");
`endif

endmodule

/* rtl/piecewise_linear_time_warp_table.sv */
// Piecewise-linear time warp table. Holds up to TABLE_DEPTH keypoints
// (local time, warped time) in two memories and serves load, forward map,
// inverse map and remap requests, one at a time, each giving one result.
// A map scans up to TABLE_DEPTH entries of the table, plus one interpolation
// when the point falls between keys. A remap is a map, a scan and shift of
// up to TABLE_DEPTH entries, then a pass over the neighbors that costs one
// interpolation per re-spaced entry, or a read and a write per shifted entry.
// Interpolation uses the serial multiply/divide of the interpolation unit.
// A finished result waits in an output register while the next request is
// taken. No clearing pass runs after reset; the entry count is cleared.
// Depends on pwtw_pkg, pwtw_table and pwtw_lerp.
module piecewise_linear_time_warp_table #(
   parameter int TABLE_DEPTH = 16,
   parameter int TIME_BITS   = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_type,
   input  logic signed [TIME_BITS-1:0] req_time_a,
   input  logic signed [TIME_BITS-1:0] req_time_b,
   input  logic                        req_restart,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [TIME_BITS-1:0] rsp_mapped_time,
   output logic [1:0]                  rsp_status
);
   import pwtw_pkg::*;

   localparam int W  = TIME_BITS;
   localparam int TW = W + 1;
   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic signed [W-1:0]   TMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0]   TMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W+1:0]   SMAX = {3'b000, {(W-1){1'b1}}};
   localparam logic signed [W+1:0]   SMIN = {3'b111, {(W-1){1'b0}}};

   typedef enum logic [4:0] {
      S_IDLE, S_LOAD, S_M1, S_M2, S_MSCAN, S_MLERP, S_MEND, S_RSCAN, S_SHIFT,
      S_INS, S_UP0, S_UP1, S_ASCAN, S_DN0, S_DN1, S_JSCAN, S_SV_RD, S_SV_WR,
      S_RS_RD, S_RS_GO, S_RS_WT, S_DONE
   } state_type;

   state_type           state_ff, state_in;
   req_code_type        op_ff, op_in;
   status_code_type     status_ff, status_in;
   logic signed [W-1:0] a_ff, a_in;
   logic signed [W-1:0] b_ff, b_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       i_ff, i_in;
   logic [CW-1:0]       lim_ff, lim_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic                fwd_ff, fwd_in;
   logic signed [W-1:0] pf_ff, pf_in;
   logic signed [W-1:0] pt_ff, pt_in;
   logic signed [W-1:0] res_ff, res_in;
   logic signed [W-1:0] ns_ff, ns_in;
   logic signed [W-1:0] ne_ff, ne_in;
   logic signed [W-1:0] os_ff, os_in;
   logic [TW-1:0]       dm_ff, dm_in;
   logic                dneg_ff, dneg_in;
   logic                hit_ff, hit_in;
   logic                clamp_ff, clamp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0] rsp_mapped_ff, rsp_mapped_in;
   status_code_type     rsp_status_ff, rsp_status_in;

   tbl_wen_type         wen;
   logic [CW-1:0]       rd_ptr;
   logic [CW-1:0]       wr_ptr;
   logic [W-1:0]        wr_time;
   logic [W-1:0]        wr_value;
   logic [W-1:0]        rd_time;
   logic [W-1:0]        rd_value;
   logic signed [W-1:0] rd_time_s;
   logic signed [W-1:0] rd_value_s;
   logic signed [W-1:0] from_s;
   logic signed [W-1:0] to_s;
   logic signed [W-1:0] js_os;
   logic signed [W-1:0] sv_val;

   logic                lerp_start;
   logic signed [W-1:0] lerp_a;
   logic signed [W-1:0] lerp_b;
   logic [TW-1:0]       lerp_nm;
   logic [TW-1:0]       lerp_dm;
   lerp_sign_type       lerp_sg;
   logic                lerp_done;
   logic signed [W-1:0] lerp_res;

   function automatic logic signed [W-1:0] sat_add3(input logic signed [W-1:0] x,
                                                    input logic signed [W-1:0] y,
                                                    input logic signed [W-1:0] z);
      logic signed [W+1:0] s;
      s = $signed({{2{x[W-1]}}, x}) + $signed({{2{y[W-1]}}, y})
        - $signed({{2{z[W-1]}}, z});
      if (s > SMAX) begin
         return TMAX;
      end else if (s < SMIN) begin
         return TMIN;
      end
      return s[W-1:0];
   endfunction

   function automatic logic [TW-1:0] magd(input logic signed [W-1:0] x,
                                          input logic signed [W-1:0] y);
      logic signed [W:0] d;
      d = $signed({x[W-1], x}) - $signed({y[W-1], y});
      return d[W] ? TW'(-d) : TW'(d);
   endfunction

   assign rd_time_s  = $signed(rd_time);
   assign rd_value_s = $signed(rd_value);
   assign from_s     = fwd_ff ? rd_time_s : rd_value_s;
   assign to_s       = fwd_ff ? rd_value_s : rd_time_s;
   assign js_os      = (rd_value_s > b_ff) ? pf_ff : rd_value_s;
   assign sv_val     = (clamp_ff && sat_add3(rd_value_s, b_ff, a_ff) < 0)
                     ? '0 : sat_add3(rd_value_s, b_ff, a_ff);

   pwtw_table #(
      .DEPTH (TABLE_DEPTH),
      .W     (W)
   ) u_table (
      .clock    (clock),
      .wr_en    (wen),
      .wr_addr  (wr_ptr[IW-1:0]),
      .wr_time  (wr_time),
      .wr_value (wr_value),
      .rd_addr  (rd_ptr[IW-1:0]),
      .rd_time  (rd_time),
      .rd_value (rd_value)
   );

   pwtw_lerp #(
      .W (W)
   ) u_lerp (
      .clock   (clock),
      .reset   (reset),
      .start   (lerp_start),
      .base_a  (lerp_a),
      .end_b   (lerp_b),
      .num_mag (lerp_nm),
      .den_mag (lerp_dm),
      .signs   (lerp_sg),
      .done    (lerp_done),
      .result  (lerp_res)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      status_in     = status_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      count_in      = count_ff;
      i_in          = i_ff;
      lim_in        = lim_ff;
      idx_in        = idx_ff;
      fwd_in        = fwd_ff;
      pf_in         = pf_ff;
      pt_in         = pt_ff;
      res_in        = res_ff;
      ns_in         = ns_ff;
      ne_in         = ne_ff;
      os_in         = os_ff;
      dm_in         = dm_ff;
      dneg_in       = dneg_ff;
      hit_in        = hit_ff;
      clamp_in      = clamp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_mapped_in = rsp_mapped_ff;
      rsp_status_in = rsp_status_ff;
      wen           = '0;
      rd_ptr        = '0;
      wr_ptr        = '0;
      wr_time       = rd_time;
      wr_value      = rd_value;
      lerp_start    = 1'b0;
      lerp_a        = pt_ff;
      lerp_b        = to_s;
      lerp_nm       = magd(a_ff, pf_ff);
      lerp_dm       = magd(from_s, pf_ff);
      lerp_sg       = '0;
      case (state_ff)
         S_IDLE: begin
            rd_ptr = count_ff - CW'(1);
            if (req_valid) begin
               op_in     = req_code_type'(req_type);
               a_in      = req_time_a;
               b_in      = req_time_b;
               fwd_in    = req_code_type'(req_type) == REQ_FWD;
               status_in = STAT_OK;
               res_in    = '0;
               case (req_code_type'(req_type))
                  REQ_LOAD: begin
                     if (req_restart) begin
                        count_in = '0;
                     end
                     state_in = S_LOAD;
                  end
                  default: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_M1;
                     end
                  end
               endcase
            end
         end
         S_LOAD: begin
            if (count_ff >= CW'(TABLE_DEPTH)) begin
               status_in = STAT_FULL;
            end else if (count_ff != '0 && (a_ff < rd_time_s || a_ff < rd_value_s)) begin
               status_in = STAT_ORDER;
            end else begin
               wen      = '{times: 1'b1, values: 1'b1};
               wr_ptr   = count_ff;
               wr_time  = a_ff;
               wr_value = a_ff;
               count_in = count_ff + CW'(1);
            end
            state_in = S_DONE;
         end
         S_M1: begin
            pf_in    = from_s;
            pt_in    = to_s;
            rd_ptr   = '0;
            state_in = S_M2;
         end
         S_M2: begin
            if (a_ff >= pf_ff) begin
               res_in   = sat_add3(pt_ff, a_ff, pf_ff);
               state_in = S_MEND;
            end else if (a_ff <= from_s) begin
               res_in   = sat_add3(to_s, a_ff, from_s);
               state_in = S_MEND;
            end else begin
               pf_in    = from_s;
               pt_in    = to_s;
               i_in     = CW'(1);
               rd_ptr   = CW'(1);
               state_in = S_MSCAN;
            end
         end
         S_MSCAN: begin
            if ((i_ff + CW'(1)) < count_ff && from_s < a_ff) begin
               pf_in  = from_s;
               pt_in  = to_s;
               i_in   = i_ff + CW'(1);
               rd_ptr = i_ff + CW'(1);
            end else if (from_s == a_ff) begin
               res_in   = to_s;
               state_in = S_MEND;
            end else begin
               lerp_start = 1'b1;
               state_in   = S_MLERP;
            end
         end
         S_MLERP: begin
            if (lerp_done) begin
               res_in   = lerp_res;
               state_in = S_MEND;
            end
         end
         S_MEND: begin
            if (op_ff == REQ_REMAP) begin
               i_in     = '0;
               hit_in   = 1'b0;
               rd_ptr   = '0;
               state_in = S_RSCAN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_RSCAN: begin
            if (i_ff < count_ff && rd_time_s <= res_ff) begin
               hit_in = rd_time_s == res_ff;
               i_in   = i_ff + CW'(1);
               rd_ptr = i_ff + CW'(1);
            end else if (i_ff != '0 && hit_ff) begin
               idx_in   = i_ff - CW'(1);
               wen      = '{times: 1'b0, values: 1'b1};
               wr_ptr   = i_ff - CW'(1);
               wr_value = b_ff;
               state_in = S_UP0;
            end else if (count_ff >= CW'(TABLE_DEPTH)) begin
               status_in = STAT_FULL;
               state_in  = S_DONE;
            end else begin
               idx_in = i_ff;
               if (i_ff == count_ff) begin
                  state_in = S_INS;
               end else begin
                  i_in     = count_ff - CW'(1);
                  rd_ptr   = count_ff - CW'(1);
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            wen    = '{times: 1'b1, values: 1'b1};
            wr_ptr = i_ff + CW'(1);
            if (i_ff == idx_ff) begin
               state_in = S_INS;
            end else begin
               i_in   = i_ff - CW'(1);
               rd_ptr = i_ff - CW'(1);
            end
         end
         S_INS: begin
            wen      = '{times: 1'b1, values: 1'b1};
            wr_ptr   = idx_ff;
            wr_time  = res_ff;
            wr_value = b_ff;
            count_in = count_ff + CW'(1);
            state_in = S_UP0;
         end
         S_UP0: begin
            if ((idx_ff + CW'(1)) < count_ff) begin
               rd_ptr   = idx_ff + CW'(1);
               state_in = S_UP1;
            end else begin
               state_in = S_DN0;
            end
         end
         S_UP1: begin
            if (b_ff > rd_value_s) begin
               i_in     = idx_ff + CW'(2);
               rd_ptr   = idx_ff + CW'(2);
               state_in = S_ASCAN;
            end else begin
               state_in = S_DN0;
            end
         end
         S_ASCAN: begin
            if (i_ff < count_ff && rd_value_s <= b_ff) begin
               i_in   = i_ff + CW'(1);
               rd_ptr = i_ff + CW'(1);
            end else if (i_ff == count_ff) begin
               i_in     = idx_ff + CW'(1);
               lim_in   = count_ff;
               clamp_in = 1'b0;
               state_in = S_SV_RD;
            end else begin
               ns_in    = b_ff;
               ne_in    = rd_value_s;
               os_in    = a_ff;
               dm_in    = magd(rd_value_s, a_ff);
               dneg_in  = rd_value_s < a_ff;
               i_in     = idx_ff + CW'(1);
               lim_in   = i_ff;
               state_in = S_RS_RD;
            end
         end
         S_DN0: begin
            if (idx_ff != '0) begin
               rd_ptr   = idx_ff - CW'(1);
               state_in = S_DN1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DN1: begin
            if (b_ff < rd_value_s) begin
               i_in     = '0;
               rd_ptr   = '0;
               state_in = S_JSCAN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_JSCAN: begin
            if (i_ff < idx_ff && rd_value_s < b_ff) begin
               pf_in  = rd_value_s;
               i_in   = i_ff + CW'(1);
               rd_ptr = i_ff + CW'(1);
            end else if (rd_value_s > b_ff && i_ff == '0) begin
               lim_in   = idx_ff;
               clamp_in = 1'b1;
               state_in = S_SV_RD;
            end else begin
               ns_in    = js_os;
               ne_in    = b_ff;
               os_in    = js_os;
               dm_in    = magd(a_ff, js_os);
               dneg_in  = a_ff < js_os;
               i_in     = (rd_value_s > b_ff) ? i_ff : i_ff + CW'(1);
               lim_in   = idx_ff;
               state_in = S_RS_RD;
            end
         end
         S_SV_RD: begin
            rd_ptr = i_ff;
            if (i_ff == lim_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SV_WR;
            end
         end
         S_SV_WR: begin
            wen      = '{times: 1'b0, values: 1'b1};
            wr_ptr   = i_ff;
            wr_value = sv_val;
            i_in     = i_ff + CW'(1);
            state_in = S_SV_RD;
         end
         S_RS_RD: begin
            rd_ptr = i_ff;
            if (i_ff == lim_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_RS_GO;
            end
         end
         S_RS_GO: begin
            lerp_start = 1'b1;
            lerp_a     = ns_ff;
            lerp_b     = ne_ff;
            lerp_nm    = magd(rd_value_s, os_ff);
            lerp_dm    = dm_ff;
            lerp_sg    = '{nneg: rd_value_s < os_ff, dneg: dneg_ff};
            state_in   = S_RS_WT;
         end
         S_RS_WT: begin
            if (lerp_done) begin
               wen      = '{times: 1'b0, values: 1'b1};
               wr_ptr   = i_ff;
               wr_value = lerp_res;
               i_in     = i_ff + CW'(1);
               state_in = S_RS_RD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_mapped_in = ((op_ff == REQ_FWD || op_ff == REQ_INV)
                               && status_ff == STAT_OK) ? res_ff : '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      status_ff     <= status_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      i_ff          <= i_in;
      lim_ff        <= lim_in;
      idx_ff        <= idx_in;
      fwd_ff        <= fwd_in;
      pf_ff         <= pf_in;
      pt_ff         <= pt_in;
      res_ff        <= res_in;
      ns_ff         <= ns_in;
      ne_ff         <= ne_in;
      os_ff         <= os_in;
      dm_ff         <= dm_in;
      dneg_ff       <= dneg_in;
      hit_ff        <= hit_in;
      clamp_ff      <= clamp_in;
      rsp_mapped_ff <= rsp_mapped_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_stall       = state_ff != S_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mapped_time = rsp_mapped_ff;
   assign rsp_status      = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff != S_IDLE)
      else $error("request transfer did not start work");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && count_ff != $past(count_ff))
      |-> (count_ff == $past(count_ff) + CW'(1) || count_ff == '0))
      else $error("entry count moved by more than one");
`endif

endmodule
